// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro builds one labeled concurrent assertion, clocked on the rising
// edge and held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: hw/rtl/pctb_pkg.sv
// ----------------------------------------------------------------------------
// pctb_pkg
// Shared types and constants for the player color tint blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pctb_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned WEIGHT_W = 25;
    localparam int unsigned INFL_W   = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 25;

    // luminance rounding: product 33 bits, three-way sum 35 bits
    localparam int unsigned PROD_W = WEIGHT_W + CHAN_W;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned LUMA_SHIFT  = 24;
    localparam int unsigned BLEND_SHIFT = 16;
    localparam int unsigned TINT_SHIFT  = 8;
    localparam logic [SUM_W-1:0] LUMA_HALF = SUM_W'(8388608);
    localparam logic [INFL_W:0]  BLEND_ONE = 17'd65536;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TINT_RED     = 3'd0,
        REG_TINT_GREEN   = 3'd1,
        REG_TINT_BLUE    = 3'd2,
        REG_WEIGHT_RED   = 3'd3,
        REG_WEIGHT_GREEN = 3'd4,
        REG_WEIGHT_BLUE  = 3'd5
    } t_reg_idx;

    // reset values of the registers
    localparam logic [CHAN_W-1:0]   RST_TINT_RED     = 8'd255;
    localparam logic [CHAN_W-1:0]   RST_TINT_GREEN   = 8'd0;
    localparam logic [CHAN_W-1:0]   RST_TINT_BLUE    = 8'd0;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RED   = 25'd5016387;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_GREEN = 25'd9848226;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_BLUE  = 25'd1912603;

    // load enables for the blend stages (stage 3 to stage 5)
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
    } t_stage_en;

endpackage

`default_nettype wire

// File: hw/rtl/pctb_mix.sv
// ----------------------------------------------------------------------------
// pctb_mix
// One color channel of the blend: scales the tint by luminance, then mixes
// it with the source channel by influence over 65536. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pctb_mix (
    input  wire                            i_clk,
    input  wire pctb_pkg::t_stage_en       i_en,
    input  wire [pctb_pkg::CHAN_W-1:0]     i_tint,
    input  wire [pctb_pkg::CHAN_W-1:0]     i_luma,
    input  wire [pctb_pkg::CHAN_W-1:0]     i_src,
    input  wire [pctb_pkg::INFL_W-1:0]     i_infl,
    output logic [pctb_pkg::CHAN_W-1:0]    o_mix
);
    import pctb_pkg::*;

    localparam int unsigned TP_W = 2 * CHAN_W;
    localparam int unsigned A_W  = CHAN_W + INFL_W;
    localparam int unsigned B_W  = CHAN_W + INFL_W + 1;
    localparam int unsigned MS_W = B_W + 1;

    logic [CHAN_W-1:0]  r_tsc3, r_src3;
    logic [INFL_W-1:0]  r_infl3;
    logic [A_W-1:0]     r_a4;
    logic [B_W-1:0]     r_b4;
    logic [CHAN_W-1:0]  r_mix5;

    logic [TP_W-1:0]    tint_prod;
    logic [INFL_W:0]    inv_infl;
    logic [MS_W-1:0]    mix_sum;

    // stage 3: tint scaled by luminance / 256
    assign tint_prod = TP_W'(i_tint) * TP_W'(i_luma);

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_tsc3  <= tint_prod[TINT_SHIFT +: CHAN_W];
            r_src3  <= i_src;
            r_infl3 <= i_infl;
        end
    end

    // stage 4: the two blend products
    assign inv_infl = BLEND_ONE - {1'b0, r_infl3};

    always_ff @(posedge i_clk) begin
        if (i_en.en4) begin
            r_a4 <= A_W'(r_tsc3) * A_W'(r_infl3);
            r_b4 <= B_W'(r_src3) * B_W'(inv_infl);
        end
    end

    // stage 5: sum, drop the 16 fraction bits, keep 8
    assign mix_sum = MS_W'(r_a4) + MS_W'(r_b4);

    always_ff @(posedge i_clk) begin
        if (i_en.en5) begin
            r_mix5 <= mix_sum[BLEND_SHIFT +: CHAN_W];
        end
    end

    assign o_mix = r_mix5;

endmodule

`default_nettype wire

// File: hw/rtl/player_color_tint_blend_core.sv
// ----------------------------------------------------------------------------
// player_color_tint_blend_core
// Five-stage pipeline that tints an RGBA pixel toward the player color.
// ----------------------------------------------------------------------------
// One pixel item is accepted per clock while o_ready is high; its result
// passes through five register stages (weight products, luminance sum,
// tint scale, blend products, blend sum). Throughput is one item per cycle
// while the output takes results, as each ready stage takes a new item.
// Each stage holds its item while the stage after it is full, so a stall on
// the output backs up stage by stage and no item is lost or repeated, and
// empty stages fill even while a finished result waits. Configuration
// writes are always taken (o_cfg_ready is high) and must only be issued
// while the pipeline is empty; indexes past the last register are ignored.
`default_nettype none

module player_color_tint_blend_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write channel
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [pctb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [pctb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel input channel
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire [pctb_pkg::CHAN_W-1:0]       i_src_red,
    input  wire [pctb_pkg::CHAN_W-1:0]       i_src_green,
    input  wire [pctb_pkg::CHAN_W-1:0]       i_src_blue,
    input  wire [pctb_pkg::CHAN_W-1:0]       i_src_alpha,
    input  wire [pctb_pkg::CHAN_W-1:0]       i_mask_red,
    input  wire [pctb_pkg::CHAN_W-1:0]       i_mask_alpha,
    // result channel
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [pctb_pkg::CHAN_W-1:0]      o_out_red,
    output logic [pctb_pkg::CHAN_W-1:0]      o_out_green,
    output logic [pctb_pkg::CHAN_W-1:0]      o_out_blue,
    output logic [pctb_pkg::CHAN_W-1:0]      o_out_alpha,
    output logic                             o_tinted
);
    import pctb_pkg::*;

    `include "assert_macros.svh"

    // configuration registers
    logic [CHAN_W-1:0]   r_tint_red, r_tint_green, r_tint_blue;
    logic [WEIGHT_W-1:0] r_weight_red, r_weight_green, r_weight_blue;

    // pipeline valid bits and stage readiness
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    t_stage_en stage_en;

    // stage 1
    logic [PROD_W-1:0] r_pr1, r_pg1, r_pb1;
    logic [INFL_W-1:0] r_infl1;
    logic [CHAN_W-1:0] r_sr1, r_sg1, r_sb1, r_sa1;
    // stage 2
    logic [CHAN_W-1:0] r_luma2;
    logic [INFL_W-1:0] r_infl2;
    logic [CHAN_W-1:0] r_sr2, r_sg2, r_sb2, r_sa2;
    logic              r_hit2;
    // side data for stages 3 to 5
    logic [CHAN_W-1:0] r_sa3, r_sa4, r_sa5;
    logic              r_hit3, r_hit4, r_hit5;

    logic [SUM_W-1:0]  luma_sum;
    logic [CHAN_W-1:0] luma;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_red     <= RST_TINT_RED;
            r_tint_green   <= RST_TINT_GREEN;
            r_tint_blue    <= RST_TINT_BLUE;
            r_weight_red   <= RST_WEIGHT_RED;
            r_weight_green <= RST_WEIGHT_GREEN;
            r_weight_blue  <= RST_WEIGHT_BLUE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TINT_RED:     r_tint_red     <= i_cfg_data[CHAN_W-1:0];
                REG_TINT_GREEN:   r_tint_green   <= i_cfg_data[CHAN_W-1:0];
                REG_TINT_BLUE:    r_tint_blue    <= i_cfg_data[CHAN_W-1:0];
                REG_WEIGHT_RED:   r_weight_red   <= i_cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_GREEN: r_weight_green <= i_cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_BLUE:  r_weight_blue  <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage can load when it is empty or its item moves on
    assign rdy5 = !r_v5 || i_ready;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign stage_en.en3 = rdy3;
    assign stage_en.en4 = rdy4;
    assign stage_en.en5 = rdy5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // stage 1: weighted channel products and influence
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_pr1   <= PROD_W'(r_weight_red)   * PROD_W'(i_src_red);
            r_pg1   <= PROD_W'(r_weight_green) * PROD_W'(i_src_green);
            r_pb1   <= PROD_W'(r_weight_blue)  * PROD_W'(i_src_blue);
            r_infl1 <= INFL_W'(i_mask_red) * INFL_W'(i_mask_alpha);
            r_sr1   <= i_src_red;
            r_sg1   <= i_src_green;
            r_sb1   <= i_src_blue;
            r_sa1   <= i_src_alpha;
        end
    end

    // stage 2: rounded luminance, saturated at 255
    assign luma_sum = SUM_W'(r_pr1) + SUM_W'(r_pg1) + SUM_W'(r_pb1) + LUMA_HALF;
    assign luma = (luma_sum[SUM_W-1:LUMA_SHIFT+CHAN_W] != '0) ? '1
                                                              : luma_sum[LUMA_SHIFT +: CHAN_W];

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_luma2 <= luma;
            r_infl2 <= r_infl1;
            r_hit2  <= (r_infl1 != '0);
            r_sr2   <= r_sr1;
            r_sg2   <= r_sg1;
            r_sb2   <= r_sb1;
            r_sa2   <= r_sa1;
        end
    end

    // stages 3 to 5: alpha and tint flag ride along with the blend
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_sa3  <= r_sa2;
            r_hit3 <= r_hit2;
        end
        if (rdy4) begin
            r_sa4  <= r_sa3;
            r_hit4 <= r_hit3;
        end
        if (rdy5) begin
            r_sa5  <= r_sa4;
            r_hit5 <= r_hit4;
        end
    end

    // per-channel blend; zero influence reduces to the source channel
    pctb_mix u_mix_red (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_tint (r_tint_red),
        .i_luma (r_luma2),
        .i_src  (r_sr2),
        .i_infl (r_infl2),
        .o_mix  (o_out_red)
    );

    pctb_mix u_mix_green (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_tint (r_tint_green),
        .i_luma (r_luma2),
        .i_src  (r_sg2),
        .i_infl (r_infl2),
        .o_mix  (o_out_green)
    );

    pctb_mix u_mix_blue (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_tint (r_tint_blue),
        .i_luma (r_luma2),
        .i_src  (r_sb2),
        .i_infl (r_infl2),
        .o_mix  (o_out_blue)
    );

    assign o_valid     = r_v5;
    assign o_out_alpha = r_sa5;
    assign o_tinted    = r_hit5;

    // a blocked item in stage 1 is still there next cycle
    `ASSERT_NEXT(a_stage1_hold, i_clk, i_rst_n, r_v1 && !rdy2, r_v1)
    // input ready means the pipe is not full and stalled
    `ASSERT_SAME(a_ready_room, i_clk, i_rst_n, o_ready,
                 !(r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_ready))
    // an item that leaves stage 4 while the output is free shows up in stage 5
    `ASSERT_NEXT(a_stage5_fill, i_clk, i_rst_n, r_v4 && rdy5, r_v5)

endmodule

`default_nettype wire
